// ===== rtl/core/shc_pkg.sv =====
`default_nettype none
package shc_pkg;

    localparam int BANDS_DEF     = 64;
    localparam int MAX_ORDER_DEF = 8;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 35;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [30:0] Q30_ONE    = 31'd1073741824;
    localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam logic [30:0] HALF_PI    = 31'd1686629713;
    localparam logic [61:0] HARM_LIMIT = 62'd2061584303;
    localparam logic [19:0] TRIG_MAX   = 20'd131072;
    localparam logic [4:0]  SHIFT_MAX  = 5'd23;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_ENABLE = 2'd0,
        CFG_TOTAL  = 2'd1,
        CFG_START  = 2'd2,
        CFG_LOGR   = 2'd3
    } t_cfg_idx;

    // floor(2^34 / d) for every divisor the sequencer uses
    function automatic logic [MUL_B_W-1:0] recip(input logic [6:0] d);
        logic [MUL_B_W-1:0] m;
        begin
            case (d)
                7'd1:    m = 35'd17179869184;
                7'd2:    m = 35'd8589934592;
                7'd3:    m = 35'd5726623061;
                7'd4:    m = 35'd4294967296;
                7'd5:    m = 35'd3435973836;
                7'd6:    m = 35'd2863311530;
                7'd7:    m = 35'd2454267026;
                7'd8:    m = 35'd2147483648;
                7'd9:    m = 35'd1908874353;
                7'd10:   m = 35'd1717986918;
                7'd20:   m = 35'd858993459;
                7'd42:   m = 35'd409044504;
                7'd72:   m = 35'd238609294;
                7'd110:  m = 35'd156180628;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] acc, input logic [41:0] term);
        logic [64:0] sum;
        logic [63:0] res;
        begin
            sum = {acc[63], acc} + {{23{term[41]}}, term};
            if (sum[64] != sum[63]) begin
                res = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
                res = sum[63:0];
            end
            return res;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sweep_harmonic_correlator.sv =====
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    i_cmd, i_sample_index, i_in_sample,
//                                                i_out_sample, i_sel_band, i_sel_order,
//                                                i_sel_part
// out      output     o_out_valid / i_out_stall  o_acc_value, o_band_count
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item at a time through a single shared 33x35 multiplier under the sequencer.
// Sample: accept, the serial divider, the increment, then the fundamental and each harmonic
// order in use, a skip for each order not in use, and the band count update to close. An
// ignored sample or an unused command leaves the block in idle. Read: memory read, then the
// result register. Reset and clear run a zeroing pass over every accumulator and count
// entry with o_in_stall high. A held result stalls the next read.
`default_nettype none
module sweep_harmonic_correlator
    import shc_pkg::*;
#(
    parameter int BANDS     = BANDS_DEF,
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [31:0]        i_sample_index,
    input  wire logic signed [23:0] i_in_sample,
    input  wire logic signed [23:0] i_out_sample,
    input  wire logic [5:0]         i_sel_band,
    input  wire logic [3:0]         i_sel_order,
    input  wire logic               i_sel_part,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [63:0]      o_acc_value,
    output logic [31:0]             o_band_count,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    localparam int BW  = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int OW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int RW  = $clog2(MAX_ORDER + 2);
    localparam int CW  = 1 + OW + BW;
    localparam logic [BW-1:0] BAND_LAST = BW'(BANDS - 1);

    typedef enum logic [27:0] {
        S_IDLE   = 28'd1 << 0,
        S_CLR    = 28'd1 << 1,
        S_DIV    = 28'd1 << 2,
        S_BAND   = 28'd1 << 3,
        S_LX     = 28'd1 << 4,
        S_LY     = 28'd1 << 5,
        S_LT     = 28'd1 << 6,
        S_T      = 28'd1 << 7,
        S_EXP    = 28'd1 << 8,
        S_DV1    = 28'd1 << 9,
        S_DV2    = 28'd1 << 10,
        S_DV3    = 28'd1 << 11,
        S_INC1   = 28'd1 << 12,
        S_INC2   = 28'd1 << 13,
        S_ORD    = 28'd1 << 14,
        S_QA     = 28'd1 << 15,
        S_QA2    = 28'd1 << 16,
        S_QA2W   = 28'd1 << 17,
        S_QM1    = 28'd1 << 18,
        S_QS     = 28'd1 << 19,
        S_QR     = 28'd1 << 20,
        S_ACC0   = 28'd1 << 21,
        S_ACC1   = 28'd1 << 22,
        S_ACC2   = 28'd1 << 23,
        S_CNT_RD = 28'd1 << 24,
        S_CNT_WR = 28'd1 << 25,
        S_RD1    = 28'd1 << 26,
        S_RD2    = 28'd1 << 27
    } t_state;

    t_state r_state;

    logic        r_enable;
    logic [31:0] r_total, r_start, r_logr;

    logic [31:0] r_phase;
    logic [23:0] r_in, r_out;
    logic [5:0]  r_sel_band;
    logic [3:0]  r_sel_order;
    logic        r_sel_part;

    logic [CW-1:0]     r_clr;
    logic [31:0]       r_rem, r_pos;
    logic [4:0]        r_dcnt;
    logic [BW-1:0]     r_band;
    logic [4:0]        r_n;
    logic [29:0]       r_t;
    logic [31:0]       r_p;
    logic [3:0]        r_k;
    logic              r_ctx_sine;
    logic [32:0]       r_v, r_q0;
    logic [56:0]       r_inc;
    logic [61:0]       r_oinc;
    logic [31:0]       r_hp;
    logic [RW-1:0]     r_ord;
    logic [30:0]       r_qin;
    logic [1:0]        r_quad;
    logic              r_half;
    logic [30:0]       r_a;
    logic [31:0]       r_a2;
    logic [30:0]       r_q;
    logic [17:0]       r_lo, r_hi;
    logic [PROD_W-1:0] r_prod;

    logic              r_out_valid;
    logic [63:0]       r_acc_value;
    logic [31:0]       r_band_count;

    logic [63:0] fund_mem [2**(BW+1)];
    logic [63:0] harm_mem [2**CW];
    logic [31:0] cnt_mem  [2**BW];
    logic [63:0] r_fund_rd, r_harm_rd;
    logic [31:0] r_cnt_rd;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [6:0]         div_d;
    logic [32:0]        div_sh, rem_c, q_c;
    logic               div_ge, q_ge;
    logic [10:0]        band_raw;
    logic [32:0]        y_c;
    logic [4:0]         n_clamp;
    logic [56:0]        inc_c;
    logic [31:0]        s_c;
    logic [19:0]        trig_c;
    logic [23:0]        x_sel, x_mag;
    logic               x_neg;
    logic [17:0]        sn_mag, cs_mag;
    logic               sn_neg, cs_neg, t_neg;
    logic [41:0]        term;
    logic [63:0]        acc_old, acc_new;
    logic [BW-1:0]      sel_b;
    logic [OW-1:0]      ord_m1, sel_m1;
    logic               in_acc, ord_zero, ord_last;

    logic              fund_we, harm_we, cnt_we;
    logic [BW:0]       fund_waddr, fund_raddr;
    logic [CW-1:0]     harm_waddr, harm_raddr;
    logic [BW-1:0]     cnt_waddr, cnt_raddr;
    logic [63:0]       mem_wdata;
    logic [31:0]       cnt_wdata;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_acc_value  = r_acc_value;
    assign o_band_count = r_band_count;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign ord_zero = (r_ord == '0);
    assign ord_last = (int'(r_ord) > MAX_ORDER);
    assign ord_m1   = OW'(r_ord - 1'b1);
    assign sel_b    = BW'(r_sel_band);
    assign sel_m1   = OW'(r_sel_order - 4'd1);

    assign div_sh   = {r_rem, 1'b0};
    assign div_ge   = div_sh >= {1'b0, r_total};
    assign div_d    = r_ctx_sine ? (7'(r_k) * (7'(r_k) + 7'd1)) : {3'd0, r_k};
    assign rem_c    = r_v - r_prod[32:0];
    assign q_ge     = rem_c >= {26'd0, div_d};
    assign q_c      = r_q0 + {32'd0, q_ge};
    assign band_raw = r_prod[42:32];
    assign y_c      = r_prod[62:30];
    assign n_clamp  = (r_n > SHIFT_MAX) ? SHIFT_MAX : r_n;
    assign inc_c    = 57'(r_prod[63:30]) << n_clamp;
    assign s_c      = r_prod[61:30];
    assign trig_c   = (20'((33'(s_c) + 33'd4096) >> 13) > TRIG_MAX) ? TRIG_MAX
                    : 20'((33'(s_c) + 33'd4096) >> 13);

    assign x_sel  = ord_zero ? r_in : r_out;
    assign x_neg  = x_sel[23];
    assign x_mag  = x_neg ? (~x_sel + 24'd1) : x_sel;
    assign sn_mag = r_quad[0] ? r_hi : r_lo;
    assign cs_mag = r_quad[0] ? r_lo : r_hi;
    assign sn_neg = r_quad[1];
    assign cs_neg = r_quad[0] ^ r_quad[1];
    assign t_neg  = x_neg ^ ((r_state == S_ACC1) ? sn_neg : cs_neg);
    assign term   = t_neg ? (~{1'b0, r_prod[40:0]} + 42'd1) : {1'b0, r_prod[40:0]};
    assign acc_old = ord_zero ? r_fund_rd : r_harm_rd;
    assign acc_new = sat_add(acc_old, term);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_BAND: begin
                mul_a = 33'(r_pos);
                mul_b = 35'(BANDS);
            end
            S_LX: begin
                mul_a = 33'(r_logr);
                mul_b = 35'(r_pos);
            end
            S_LY: begin
                mul_a = 33'(r_prod[63:32]);
                mul_b = 35'(LOG2E_Q30);
            end
            S_LT: begin
                mul_a = 33'(y_c[27:0]);
                mul_b = 35'(LN2_Q32);
            end
            S_EXP: begin
                mul_a = 33'(r_t);
                mul_b = 35'(r_p);
            end
            S_DV1: begin
                mul_a = r_prod[62:30];
                mul_b = recip(div_d);
            end
            S_DV2: begin
                mul_a = r_prod[66:34];
                mul_b = 35'(div_d);
            end
            S_INC1: begin
                mul_a = 33'(r_start);
                mul_b = 35'(r_p);
            end
            S_QA: begin
                mul_a = 33'(r_qin);
                mul_b = 35'(HALF_PI);
            end
            S_QA2: begin
                mul_a = 33'(r_prod[60:30]);
                mul_b = 35'(r_prod[60:30]);
            end
            S_QM1: begin
                mul_a = 33'(r_a2);
                mul_b = 35'(r_q);
            end
            S_QS: begin
                mul_a = 33'(r_a);
                mul_b = 35'(r_q);
            end
            S_ACC0: begin
                mul_a = 33'(x_mag);
                mul_b = 35'(sn_mag);
            end
            S_ACC1: begin
                mul_a = 33'(x_mag);
                mul_b = 35'(cs_mag);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        fund_we    = 1'b0;
        harm_we    = 1'b0;
        cnt_we     = 1'b0;
        mem_wdata  = acc_new;
        cnt_wdata  = (r_cnt_rd == 32'hFFFF_FFFF) ? r_cnt_rd : r_cnt_rd + 32'd1;
        fund_waddr = {(r_state == S_ACC2), r_band};
        harm_waddr = {(r_state == S_ACC2), ord_m1, r_band};
        cnt_waddr  = r_band;
        fund_raddr = {(r_state == S_ACC1), r_band};
        harm_raddr = {(r_state == S_ACC1), ord_m1, r_band};
        cnt_raddr  = r_band;
        case (r_state)
            S_CLR: begin
                fund_we    = 1'b1;
                harm_we    = 1'b1;
                cnt_we     = 1'b1;
                mem_wdata  = '0;
                cnt_wdata  = '0;
                fund_waddr = r_clr[BW:0];
                harm_waddr = r_clr;
                cnt_waddr  = r_clr[BW-1:0];
            end
            S_ACC1, S_ACC2: begin
                fund_we = ord_zero;
                harm_we = !ord_zero;
            end
            S_CNT_WR: begin
                cnt_we = 1'b1;
            end
            S_RD1, S_RD2: begin
                fund_raddr = {r_sel_part, sel_b};
                harm_raddr = {r_sel_part, sel_m1, sel_b};
                cnt_raddr  = sel_b;
            end
            default: begin
                fund_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fund_we) begin
            fund_mem[fund_waddr] <= mem_wdata;
        end
        if (harm_we) begin
            harm_mem[harm_waddr] <= mem_wdata;
        end
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_fund_rd <= fund_mem[fund_raddr];
        r_harm_rd <= harm_mem[harm_raddr];
        r_cnt_rd  <= cnt_mem[cnt_raddr];
        r_prod    <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
            r_enable    <= 1'b0;
            r_total     <= 32'd1;
            r_start     <= 32'd1;
            r_logr      <= 32'd1;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ENABLE: r_enable <= i_cfg_data[0];
                    CFG_TOTAL:  r_total  <= i_cfg_data;
                    CFG_START:  r_start  <= i_cfg_data;
                    CFG_LOGR:   r_logr   <= i_cfg_data;
                    default:    r_enable <= r_enable;
                endcase
            end
            if ((r_state == S_RD2) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_in        <= i_in_sample;
                        r_out       <= i_out_sample;
                        r_sel_band  <= i_sel_band;
                        r_sel_order <= i_sel_order;
                        r_sel_part  <= i_sel_part;
                        case (t_cmd'(i_cmd))
                            CMD_SAMPLE: begin
                                if (r_enable && (i_sample_index < r_total)) begin
                                    r_rem   <= i_sample_index;
                                    r_dcnt  <= '0;
                                    r_state <= S_DIV;
                                end
                            end
                            CMD_READ: r_state <= S_RD1;
                            CMD_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= S_CLR;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CLR: begin
                    r_phase <= '0;
                    r_clr   <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_rem  <= div_ge ? 32'(div_sh - {1'b0, r_total}) : div_sh[31:0];
                    r_pos  <= {r_pos[30:0], div_ge};
                    r_dcnt <= r_dcnt + 5'd1;
                    if (&r_dcnt) begin
                        r_state <= S_BAND;
                    end
                end
                S_BAND: r_state <= S_LX;
                S_LX: begin
                    r_band  <= (int'(band_raw) > BANDS - 1) ? BAND_LAST : BW'(band_raw);
                    r_state <= S_LY;
                end
                S_LY: r_state <= S_LT;
                S_LT: begin
                    r_n     <= y_c[32:28];
                    r_state <= S_T;
                end
                S_T: begin
                    r_t        <= r_prod[59:30];
                    r_p        <= 32'(Q30_ONE);
                    r_k        <= 4'd10;
                    r_ctx_sine <= 1'b0;
                    r_state    <= S_EXP;
                end
                S_EXP: r_state <= S_DV1;
                S_QM1: r_state <= S_DV1;
                S_DV1: begin
                    r_v     <= r_prod[62:30];
                    r_state <= S_DV2;
                end
                S_DV2: begin
                    r_q0    <= r_prod[66:34];
                    r_state <= S_DV3;
                end
                S_DV3: begin
                    if (r_ctx_sine) begin
                        r_q <= 31'(33'(Q30_ONE) - q_c);
                        if (r_k == 4'd2) begin
                            r_state <= S_QS;
                        end else begin
                            r_k     <= r_k - 4'd2;
                            r_state <= S_QM1;
                        end
                    end else begin
                        r_p <= 32'(33'(Q30_ONE) + q_c);
                        if (r_k == 4'd1) begin
                            r_state <= S_INC1;
                        end else begin
                            r_k     <= r_k - 4'd1;
                            r_state <= S_EXP;
                        end
                    end
                end
                S_INC1: r_state <= S_INC2;
                S_INC2: begin
                    r_inc   <= inc_c;
                    r_oinc  <= 62'(inc_c);
                    r_hp    <= r_phase;
                    r_ord   <= '0;
                    r_state <= S_ORD;
                end
                S_ORD: begin
                    if (ord_zero) begin
                        r_qin   <= {1'b0, r_phase[29:0]};
                        r_quad  <= r_phase[31:30];
                        r_half  <= 1'b0;
                        r_state <= S_QA;
                    end else if (ord_last) begin
                        r_state <= S_CNT_RD;
                    end else if (r_oinc < HARM_LIMIT) begin
                        r_qin   <= {1'b0, r_hp[29:0]};
                        r_quad  <= r_hp[31:30];
                        r_half  <= 1'b0;
                        r_state <= S_QA;
                    end else begin
                        r_ord  <= r_ord + 1'b1;
                        r_hp   <= r_hp + r_phase;
                        r_oinc <= r_oinc + 62'(r_inc);
                    end
                end
                S_QA: r_state <= S_QA2;
                S_QA2: begin
                    r_a     <= r_prod[60:30];
                    r_state <= S_QA2W;
                end
                S_QA2W: begin
                    r_a2       <= r_prod[61:30];
                    r_q        <= Q30_ONE;
                    r_k        <= 4'd10;
                    r_ctx_sine <= 1'b1;
                    r_state    <= S_QM1;
                end
                S_QS: r_state <= S_QR;
                S_QR: begin
                    if (!r_half) begin
                        r_lo    <= trig_c[17:0];
                        r_qin   <= Q30_ONE - r_qin;
                        r_half  <= 1'b1;
                        r_state <= S_QA;
                    end else begin
                        r_hi    <= trig_c[17:0];
                        r_state <= S_ACC0;
                    end
                end
                S_ACC0: r_state <= S_ACC1;
                S_ACC1: r_state <= S_ACC2;
                S_ACC2: begin
                    r_ord <= r_ord + 1'b1;
                    if (!ord_zero) begin
                        r_hp   <= r_hp + r_phase;
                        r_oinc <= r_oinc + 62'(r_inc);
                    end
                    r_state <= S_ORD;
                end
                S_CNT_RD: r_state <= S_CNT_WR;
                S_CNT_WR: begin
                    r_phase <= r_phase + r_inc[31:0];
                    r_state <= S_IDLE;
                end
                S_RD1: r_state <= S_RD2;
                S_RD2: begin
                    if (!r_out_valid || !i_out_stall) begin
                        if (int'(r_sel_band) >= BANDS) begin
                            r_acc_value  <= '0;
                            r_band_count <= '0;
                        end else begin
                            r_band_count <= r_cnt_rd;
                            if (r_sel_order == 4'd0) begin
                                r_acc_value <= r_fund_rd;
                            end else if (int'(r_sel_order) <= MAX_ORDER) begin
                                r_acc_value <= r_harm_rd;
                            end else begin
                                r_acc_value <= '0;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== bench/sweep_harmonic_correlator_tb.sv =====
module sweep_harmonic_correlator_tb;
    import shc_pkg::*;

    localparam int NB = 64;
    localparam int NO = 8;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 1200;
    localparam logic [63:0] ONE30 = 64'd1073741824;

    class acc_scoreboard;
        bit          en;
        logic [31:0] total;
        logic [31:0] start;
        logic [31:0] logr;
        logic [31:0] phase;
        longint      fund[2][NB];
        longint      harm[2][NO][NB];
        logic [31:0] cnt[NB];
        longint      exp_acc[$];
        logic [31:0] exp_cnt[$];
        int          errors;

        function new();
            en = 0;
            total = 1;
            start = 1;
            logr = 1;
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            phase = '0;
            for (int b = 0; b < NB; b++) begin
                cnt[b] = '0;
                for (int p = 0; p < 2; p++) begin
                    fund[p][b] = 0;
                    for (int o = 0; o < NO; o++) harm[p][o][b] = 0;
                end
            end
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] d);
            case (idx)
                CFG_ENABLE: en = d[0];
                CFG_TOTAL:  total = d;
                CFG_START:  start = d;
                CFG_LOGR:   logr = d;
                default: ;
            endcase
        endfunction

        function longint sat_sum(longint a, longint b);
            longint mx;
            longint mn;
            mx = 64'sh7FFF_FFFF_FFFF_FFFF;
            mn = 64'sh8000_0000_0000_0000;
            if (b > 0 && a > mx - b) return mx;
            if (b < 0 && a < mn - b) return mn;
            return a + b;
        endfunction

        function longint qsine(logic [63:0] r);
            logic [63:0] a;
            logic [63:0] a2;
            logic [63:0] q;
            logic [63:0] s;
            logic [63:0] k;
            a = (r * 64'd1686629713) >> 30;
            a2 = (a * a) >> 30;
            q = ONE30;
            for (k = 10; k >= 2; k = k - 2) q = ONE30 - ((a2 * q) >> 30) / (k * (k + 1));
            s = ((a * q) >> 30);
            s = (s + 64'd4096) >> 13;
            if (s > 64'd131072) s = 64'd131072;
            return longint'(s);
        endfunction

        function void trig(logic [31:0] ph, output longint sn, output longint cs);
            longint lo;
            longint hi;
            lo = qsine({34'd0, ph[29:0]});
            hi = qsine(ONE30 - {34'd0, ph[29:0]});
            case (ph[31:30])
                2'd0: begin sn = lo;  cs = hi;  end
                2'd1: begin sn = hi;  cs = -lo; end
                2'd2: begin sn = -lo; cs = -hi; end
                default: begin sn = -hi; cs = lo; end
            endcase
        endfunction

        function logic [63:0] step_inc(logic [63:0] pos);
            logic [63:0] x;
            logic [63:0] y;
            logic [63:0] n;
            logic [63:0] f;
            logic [63:0] t;
            logic [63:0] p;
            logic [63:0] k;
            logic [63:0] m;
            x = ({32'd0, logr} * pos) >> 32;
            y = (x * 64'd1549082005) >> 30;
            n = y >> 28;
            f = y & 64'hFFF_FFFF;
            t = (f * 64'd2977044472) >> 30;
            p = ONE30;
            for (k = 10; k >= 1; k--) p = ONE30 + ((t * p) >> 30) / k;
            if (n > 23) n = 23;
            m = ({32'd0, start} * p) >> 30;
            return m << n;
        endfunction

        function void note_input(t_cmd c, logic [31:0] idx, logic signed [23:0] xi,
                                 logic signed [23:0] xo, logic [5:0] sb, logic [3:0] so,
                                 logic sp);
            logic [63:0] pos;
            logic [63:0] inc;
            logic [63:0] hp;
            int          band;
            longint      sn;
            longint      cs;
            longint      vi;
            longint      vo;
            longint      acc;
            case (c)
                CMD_SAMPLE: begin
                    if (!en || idx >= total) return;
                    pos = ({32'd0, idx} << 32) / {32'd0, total};
                    band = int'((pos * NB) >> 32);
                    if (band > NB - 1) band = NB - 1;
                    inc = step_inc(pos);
                    vi = longint'(xi);
                    vo = longint'(xo);
                    trig(phase, sn, cs);
                    fund[0][band] = sat_sum(fund[0][band], vi * sn);
                    fund[1][band] = sat_sum(fund[1][band], vi * cs);
                    for (int o = 1; o <= NO; o++) begin
                        if (inc * o < 64'd2061584303) begin
                            hp = {32'd0, phase} * o;
                            trig(hp[31:0], sn, cs);
                            harm[0][o-1][band] = sat_sum(harm[0][o-1][band], vo * sn);
                            harm[1][o-1][band] = sat_sum(harm[1][o-1][band], vo * cs);
                        end
                    end
                    if (cnt[band] != 32'hFFFF_FFFF) cnt[band]++;
                    phase = phase + inc[31:0];
                end
                CMD_CLEAR: wipe();
                CMD_READ: begin
                    acc = 0;
                    if (so == 0) acc = fund[sp][sb];
                    else if (so <= NO) acc = harm[sp][so-1][sb];
                    exp_acc.insert(exp_acc.size(), acc);
                    exp_cnt.insert(exp_cnt.size(), cnt[sb]);
                end
                default: ;
            endcase
        endfunction

        function void check_result(longint acc, logic [31:0] bc);
            longint      ea;
            logic [31:0] ec;
            if (exp_acc.size() == 0) begin
                $error("unexpected result acc_value %0d band_count %0d", acc, bc);
                errors++;
                return;
            end
            ea = exp_acc.pop_front();
            ec = exp_cnt.pop_front();
            if (acc !== ea) begin
                $error("acc_value expected %0d actual %0d", ea, acc);
                errors++;
            end
            if (bc !== ec) begin
                $error("band_count expected %0d actual %0d", ec, bc);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_cmd = '0;
    logic [31:0]        i_sample_index = '0;
    logic signed [23:0] i_in_sample = '0;
    logic signed [23:0] i_out_sample = '0;
    logic [5:0]         i_sel_band = '0;
    logic [3:0]         i_sel_order = '0;
    logic               i_sel_part = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [63:0] o_acc_value;
    logic [31:0]        o_band_count;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    acc_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;

    sweep_harmonic_correlator u_top (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[sweep_harmonic_correlator] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_acc_value, o_band_count);
    end

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.exp_acc.size() != 0) @(posedge i_clk);
    endtask

    task automatic configure(bit en, logic [31:0] tot, logic [31:0] st, logic [31:0] lr);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        cfg_write(CFG_ENABLE, {31'd0, en});
        cfg_write(CFG_TOTAL, tot);
        cfg_write(CFG_START, st);
        cfg_write(CFG_LOGR, lr);
    endtask

    task automatic send_item(t_cmd c, logic [31:0] idx, logic [23:0] xi, logic [23:0] xo,
                             logic [5:0] b, logic [3:0] o, logic p);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_cmd <= c;
        i_sample_index <= idx;
        i_in_sample <= xi;
        i_out_sample <= xo;
        i_sel_band <= b;
        i_sel_order <= o;
        i_sel_part <= p;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(c, idx, xi, xo, b, o, p);
    endtask

    task automatic send_sample(logic [31:0] idx, logic [23:0] xi, logic [23:0] xo);
        send_item(CMD_SAMPLE, idx, xi, xo, 6'($urandom), 4'($urandom), 1'($urandom));
    endtask

    task automatic send_read(logic [5:0] b, logic [3:0] o, logic p);
        send_item(CMD_READ, $urandom, 24'($urandom), 24'($urandom), b, o, p);
    endtask

    task automatic random_phase(int n, logic [31:0] tot);
        logic [31:0] seq;
        logic [31:0] idx;
        int          r;
        seq = 0;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) begin
                i_in_valid <= 1'b0;
                wait_drained();
            end
            r = $urandom_range(99);
            if (r < 60) begin
                if ($urandom_range(9) < 8) begin
                    idx = (tot < 1024) ? seq % (tot + 2) : seq;
                    seq++;
                end else begin
                    idx = $urandom;
                end
                send_sample(idx, 24'($urandom), 24'($urandom));
            end else if (r < 92) begin
                send_read(6'($urandom), 4'($urandom), 1'($urandom));
            end else if (r < 96) begin
                send_item(CMD_CLEAR, $urandom, 24'($urandom), 24'($urandom),
                          6'($urandom), 4'($urandom), 1'($urandom));
                seq = 0;
            end else begin
                send_item(CMD_NONE, $urandom, 24'($urandom), 24'($urandom),
                          6'($urandom), 4'($urandom), 1'($urandom));
            end
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_sample(0, 24'h7FFFFF, 24'h800000);
        send_read(0, 0, 0);
        configure(1, 64, 32'h0100_0000, 32'h2C5C_85FE);
        send_sample(0, 24'h7FFFFF, 24'h7FFFFF);
        send_sample(1, 24'h800000, 24'h800000);
        send_sample(63, 24'h800000, 24'h7FFFFF);
        send_sample(64, 24'h123456, 24'h654321);
        send_sample(32'hFFFF_FFFF, 24'h7FFFFF, 24'h7FFFFF);
        for (int o = 0; o <= 9; o++) send_read((o < 5) ? 6'd0 : 6'd1, 4'(o), 1'(o));
        send_read(6'd63, 4'd1, 1'b0);
        send_read(6'd63, 4'd15, 1'b1);
        send_item(CMD_NONE, 0, 0, 0, 0, 0, 0);
        send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        send_read(6'd0, 4'd0, 1'b0);
        send_read(6'd63, 4'd8, 1'b1);
        i_in_valid <= 1'b0;

        for (int ph = 0; ph < 5; ph++) begin
            idle_pct = (ph % 4 == 1) ? 80 : (ph % 4 == 3) ? 20 : 0;
            stall_pct = (ph % 4 == 2) ? 80 : (ph % 4 == 3) ? 20 : 0;
            case (ph)
                0: begin
                    configure(1, 256, $urandom_range(32'h1_0000, 32'h400_0000), $urandom);
                    random_phase(160, 256);
                end
                1: begin
                    configure(1, 1, 32'h8000_0000, 32'hFFFF_FFFF);
                    random_phase(160, 1);
                end
                2: begin
                    configure(1, 32'hFFFF_FFFF, 1, 1);
                    random_phase(160, 32'hFFFF_FFFF);
                end
                3: begin
                    configure(0, $urandom_range(1, 500), $urandom, $urandom);
                    random_phase(60, sb.total);
                    configure(1, $urandom_range(1, 700), $urandom_range(1, 32'h8000_0000),
                              $urandom_range(1, 32'hFFFF_FFFF));
                    random_phase(120, sb.total);
                end
                default: begin
                    configure(1, $urandom_range(100, 900), $urandom_range(1, 32'h200_0000),
                              $urandom_range(1, 32'h4000_0000));
                    random_phase(160, sb.total);
                end
            endcase
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.exp_acc.size() == 0) begin
            $display("[sweep_harmonic_correlator] OK");
        end else begin
            $display("[sweep_harmonic_correlator] ERROR");
        end
        $finish;
    end

endmodule
